// File: rtl/core/tscg_pkg.sv
// Shared types, constants and the elaboration-time basis weight ROM for the spline generator.
package tscg_pkg;

	localparam int STEPS   = 64;
	localparam int STEP_W  = $clog2(STEPS);
	localparam int X_W     = 16;
	localparam int Y_W     = 32;
	localparam int W_W     = 17;
	localparam int PX_W    = X_W + 1 + W_W;
	localparam int PY_W    = Y_W + W_W;
	localparam int SX_W    = PX_W + 2;
	localparam int SY_W    = PY_W + 2;
	localparam int FRAC    = 15;
	localparam int DX_W    = SX_W - FRAC;
	localparam int VY_W    = SY_W - FRAC;
	localparam int DATA_W  = X_W + Y_W;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [W_W-1:0] weight_t;
	typedef logic [X_W-1:0]        px_t;
	typedef logic signed [Y_W-1:0] py_t;
	typedef weight_t [1:0][3:0][STEPS-1:0] rom_t;

	// one queued transaction from the front end
	typedef struct packed {
		logic restart;
		logic mode;
		px_t  x;
		py_t  y;
	} item_t;

	// one sample issued to the datapath
	typedef struct packed {
		logic               valid;
		logic               last;
		weight_t [3:0]      w;
		px_t [3:0]          x;
		py_t [3:0]          y;
	} issue_t;

	// sin(pi/2 * u), u and result in Q30
	function automatic logic [63:0] quarter_sin(input logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = (HALF_PI_Q30 * u) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
		return (x * t) >> 30;
	endfunction

	// round half away from zero, then shift right
	function automatic longint round_shift(input longint v, input int s);
		longint half;
		half = longint'(1) <<< (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -(((-v) + half) >>> s);
	endfunction

	function automatic rom_t build_rom();
		rom_t   r;
		longint sn;
		longint cs;
		longint one;
		logic [63:0] u;
		one = longint'(Q30_ONE);
		for (int i = 0; i < STEPS; i++) begin
			u  = (64'(i + 1) << 30) / 64'(STEPS);
			sn = longint'(quarter_sin(u));
			cs = longint'(quarter_sin(Q30_ONE - u));
			r[1][0][i] = W_W'(round_shift(cs * (cs - one), 46));
			r[1][1][i] = W_W'(round_shift(sn * (sn + one), 46));
			r[1][2][i] = W_W'(round_shift(cs * (cs + one), 46));
			r[1][3][i] = W_W'(round_shift(sn * (sn - one), 46));
			r[0][0][i] = W_W'(round_shift(one - cs, 17));
			r[0][1][i] = W_W'(round_shift(one + sn, 17));
			r[0][2][i] = W_W'(round_shift(one + cs, 17));
			r[0][3][i] = W_W'(round_shift(one - sn, 17));
		end
		return r;
	endfunction

	localparam rom_t W_ROM = build_rom();

endpackage

// File: rtl/core/tscg_front.sv
// Input side: mode register, transaction capture and a two-entry queue to the sequencer.
module tscg_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tscg_pkg::DATA_W-1:0]  s_tdata,
	input  logic                         s_tuser,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	output logic                         q_valid,
	output tscg_pkg::item_t              q_item,
	input  logic                         q_pop
);
	import tscg_pkg::*;

	logic        interp_mode_q;
	item_t [1:0] entry_q;
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       new_item;

	assign cfg_ready = 1'b1;
	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign q_valid   = (count_q != 2'd0);
	assign q_item    = entry_q[rd_ptr_q];

	always_comb begin
		new_item.restart = s_tuser;
		new_item.mode    = interp_mode_q;
		new_item.x       = s_tdata[X_W-1:0];
		new_item.y       = s_tdata[DATA_W-1:X_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q <= 1'b1;
			wr_ptr_q      <= 1'b0;
			rd_ptr_q      <= 1'b0;
			count_q       <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				interp_mode_q <= cfg_data;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// File: rtl/core/tscg_seq.sv
// Back-end sequencer: point window, step counter and weight ROM lookup per sample.
module tscg_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tscg_pkg::item_t   q_item,
	output logic              q_pop,
	input  logic              adv,
	output tscg_pkg::issue_t  iss_s1
);
	import tscg_pkg::*;

	px_t [3:0]         win_x_q;
	py_t [3:0]         win_y_q;
	logic              busy_q;
	logic              mode_q;
	logic [STEP_W-1:0] step_q;
	logic              issue;
	logic              last;

	assign last  = (step_q == STEP_W'(STEPS - 1));
	assign issue = busy_q && adv;
	assign q_pop = q_valid && (!busy_q || (issue && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_q <= '0;
			win_y_q <= '0;
			busy_q  <= 1'b0;
			mode_q  <= 1'b1;
			step_q  <= '0;
			iss_s1  <= '0;
		end else begin
			if (adv) begin
				iss_s1.valid <= issue;
			end
			if (issue) begin
				iss_s1.last <= last;
				iss_s1.x    <= win_x_q;
				iss_s1.y    <= win_y_q;
				for (int k = 0; k < 4; k++) begin
					iss_s1.w[k] <= W_ROM[mode_q][k][step_q];
				end
				step_q <= last ? '0 : step_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (q_pop) begin
				if (q_item.restart) begin
					win_x_q <= '0;
					win_y_q <= '0;
				end else begin
					win_x_q <= {q_item.x, win_x_q[3:1]};
					win_y_q <= {q_item.y, win_y_q[3:1]};
					busy_q  <= 1'b1;
					mode_q  <= q_item.mode;
					step_q  <= '0;
				end
			end
		end
	end

endmodule

// File: rtl/core/tscg_mac.sv
// Back-end datapath: products, sums, rounding, saturation and the output register.
module tscg_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tscg_pkg::issue_t             iss_s1,
	output logic                         adv,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tscg_pkg::DATA_W-1:0]  m_tdata,
	output logic                         m_tuser,
	output logic                         m_tlast
);
	import tscg_pkg::*;

	logic signed [PX_W-1:0] px_s2 [4];
	logic signed [PY_W-1:0] py_s2 [4];
	logic                   v_s2;
	logic                   last_s2;
	logic signed [SX_W-1:0] sx_s3;
	logic signed [SY_W-1:0] sy_s3;
	logic                   v_s3;
	logic                   last_s3;
	logic                   ov_q;
	logic [X_W-1:0]         idx_q;
	logic [Y_W-1:0]         val_q;
	logic                   wr_q;
	logic                   last_q;

	logic signed [SX_W-1:0] sx_r;
	logic signed [SY_W-1:0] sy_r;
	logic signed [DX_W-1:0] dx;
	logic signed [VY_W-1:0] vy;
	logic                   dx_hi;
	logic                   vy_fits;
	logic [X_W-1:0]         idx_n;
	logic [Y_W-1:0]         val_n;
	logic                   wr_n;

	assign adv      = !ov_q || m_tready;
	assign m_tvalid = ov_q;
	assign m_tdata  = {val_q, idx_q};
	assign m_tuser  = wr_q;
	assign m_tlast  = last_q;

	// round half away from zero: bias down by one for negative sums
	always_comb begin
		sx_r    = sx_s3 + SX_W'(1 << (FRAC - 1)) - SX_W'(sx_s3[SX_W-1]);
		sy_r    = sy_s3 + SY_W'(1 << (FRAC - 1)) - SY_W'(sy_s3[SY_W-1]);
		dx      = sx_r[SX_W-1:FRAC];
		vy      = sy_r[SY_W-1:FRAC];
		dx_hi   = |dx[DX_W-2:X_W];
		wr_n    = !dx[DX_W-1] && !dx_hi;
		idx_n   = dx[DX_W-1] ? '0 : (dx_hi ? '1 : dx[X_W-1:0]);
		vy_fits = (vy[VY_W-1:Y_W-1] == '0) || (vy[VY_W-1:Y_W-1] == '1);
		if (vy_fits) begin
			val_n = vy[Y_W-1:0];
		end else if (vy[VY_W-1]) begin
			val_n = {1'b1, {(Y_W-1){1'b0}}};
		end else begin
			val_n = {1'b0, {(Y_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s2 <= iss_s1.valid;
			v_s3 <= v_s2;
			ov_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= iss_s1.last;
			for (int k = 0; k < 4; k++) begin
				px_s2[k] <= $signed({1'b0, iss_s1.x[k]}) * $signed(iss_s1.w[k]);
				py_s2[k] <= $signed(iss_s1.y[k]) * $signed(iss_s1.w[k]);
			end
			last_s3 <= last_s2;
			sx_s3   <= SX_W'(px_s2[0]) + SX_W'(px_s2[1]) + SX_W'(px_s2[2]) + SX_W'(px_s2[3]);
			sy_s3   <= SY_W'(py_s2[0]) + SY_W'(py_s2[1]) + SY_W'(py_s2[2]) + SY_W'(py_s2[3]);
			last_q  <= last_s3;
			idx_q   <= idx_n;
			val_q   <= val_n;
			wr_q    <= wr_n;
		end
	end

endmodule

// File: rtl/core/trig_spline_curve_generator.sv
// Top level of the trigonometric cubic spline curve generator.
// Each point transaction (s_tuser low) shifts a four-point window and produces STEPS
// curve samples (64 by default), one per clock while m_tready stays high; the next point
// is taken from the queue as the last sample issues. The rate is set by the single
// multiply-accumulate datapath that works one sample per cycle. A restart transaction
// (s_tuser high) clears the window and produces nothing. A two-entry queue decouples input
// from the sample pipeline; on an idle block a point passes the queue, the window, issue,
// product, sum and output registers before its first sample is presented.
// cfg_data selects the interpolating (1, reset value) or exterpolating (0) basis; the
// setting in effect when a point transaction is accepted applies to it.
module trig_spline_curve_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tscg_pkg::DATA_W-1:0]  s_tdata,   // point_x[15:0], point_y[47:16]
	input  logic                         s_tuser,   // restart
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tscg_pkg::DATA_W-1:0]  m_tdata,   // curve_index[15:0], curve_value[47:16]
	output logic                         m_tuser,   // written
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data
);
	import tscg_pkg::*;

	logic     q_valid;
	item_t    q_item;
	logic     q_pop;
	logic     adv;
	issue_t   iss_s1;

	tscg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	tscg_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.adv     (adv),
		.iss_s1  (iss_s1)
	);

	tscg_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss_s1   (iss_s1),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
